// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module of the mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JDVM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Implication with a fixed delay in cycles.
`define JDVM_ASSERT_DLY(lbl, clk, rstn, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##(dly) (cons)) \
    else $error("assertion failed: delayed implication");

`endif

// ===== rtl/jdvm_pkg.sv =====
// Types, constants and codes of the joystick deadzone velocity mapper.
package jdvm_pkg;

  // Sample and register widths
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_W       = 15;
  localparam int DEN_W       = CFG_W + 1;
  localparam int REM_W       = CFG_W + 2;
  localparam int AW          = ((SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W) + 2;

  // Divider pipeline shape
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES      = (SAMPLE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int PIPE_LAT        = DIV_STAGES + 2;

  // Pedal tolerance: |x - y| * 100 < full scale means within 0.01
  localparam int TOL_FACTOR = 100;

  // Axis lanes
  localparam int AXES   = 3;
  localparam int AXIS_Y = 0;
  localparam int AXIS_X = 1;
  localparam int AXIS_Z = 2;

  localparam logic [SAMPLE_BITS-1:0] SCALE_U  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] MAXPOS_U = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  // Reset values of the registers
  localparam logic [CFG_W-1:0] DEADZONE_RST   = CFG_W'(3277);
  localparam logic [CFG_W-1:0] FULL_SCALE_RST = CFG_W'(32767);

  typedef enum logic [1:0] {
    CFG_PEDAL_MODE  = 2'd0,
    CFG_DEADZONE    = 2'd1,
    CFG_FULL_SCALE  = 2'd2,
    CFG_CONNECT_SEP = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ACT_GOAL         = 4'd0,
    ACT_PREPARE      = 4'd1,
    ACT_START        = 4'd2,
    ACT_PAUSE        = 4'd3,
    ACT_STOP         = 4'd4,
    ACT_CONNECT_BOTH = 4'd5,
    ACT_CONNECT_GOAL = 4'd6,
    ACT_CONNECT_RPC  = 4'd7,
    ACT_DISCONNECT   = 4'd8
  } action_e;

  typedef enum logic [1:0] {
    PED_NONE  = 2'd0,
    PED_MEAN  = 2'd1,
    PED_XSIDE = 2'd2,
    PED_YSIDE = 2'd3
  } ped_sel_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t axis_zero;
    sample_t axis_one;
    sample_t axis_two;
    logic    btn_prepare;
    logic    btn_start;
    logic    btn_pause;
    logic    btn_stop;
    logic    btn_connect_goal;
    logic    btn_connect_rpc;
    logic    btn_disconnect;
  } in_t;

  typedef struct packed {
    sample_t    linear_velocity;
    sample_t    angular_velocity;
    sample_t    lateral_velocity;
    logic [3:0] action;
  } out_t;

  typedef struct packed {
    logic             pedal_mode;
    logic [CFG_W-1:0] deadzone_level;
    logic [CFG_W-1:0] full_scale;
    logic             connect_separately;
  } cfg_t;

  // Per-axis divider lane
  typedef struct packed {
    logic                   zero;
    logic                   neg;
    logic                   sat;
    logic [REM_W-1:0]       rem;
    logic [SAMPLE_BITS-1:0] quo;
  } lane_t;

  // Decisions made up front that ride along with the lanes
  typedef struct packed {
    logic     pedal;
    action_e  action;
    ped_sel_e sel;
    logic     xpos;
    logic     ypos;
    sample_t  mean;
  } side_t;

  typedef struct packed {
    lane_t [AXES-1:0] lane;
    side_t            side;
  } stage_t;

endpackage

// ===== rtl/jdvm_front.sv =====
// Front stage: deadzone test, divider setup, pedal decisions and button decode.
module jdvm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  jdvm_pkg::in_t   in_i,
  input  jdvm_pkg::cfg_t  cfg_i,
  output logic            valid_o,
  output jdvm_pkg::stage_t stage_o
);

  localparam int AW = jdvm_pkg::AW;
  localparam int PW = jdvm_pkg::AW + 7;

  logic                   valid_q;
  jdvm_pkg::stage_t       stage_d, stage_q;
  jdvm_pkg::sample_t      smp [jdvm_pkg::AXES];
  logic signed [AW-1:0]   dz_s, den_s, den2_s;
  logic signed [AW-1:0]   vext [jdvm_pkg::AXES];
  logic signed [AW-1:0]   mag  [jdvm_pkg::AXES];
  logic signed [AW-1:0]   xe, ye, diff, sum;
  logic [AW-1:0]          adiff;
  logic [PW-1:0]          prod, scale_w;
  logic                   xpos, ypos, close;

  assign smp[jdvm_pkg::AXIS_Y] = in_i.axis_zero;
  assign smp[jdvm_pkg::AXIS_X] = in_i.axis_one;
  assign smp[jdvm_pkg::AXIS_Z] = in_i.axis_two;

  // Deadzone and overflow screening per axis, then pedal and button decisions
  always_comb begin
    dz_s   = signed'(AW'(cfg_i.deadzone_level));
    den_s  = signed'(AW'(cfg_i.full_scale)) - dz_s;
    den2_s = den_s <<< 1;
    for (int a = 0; a < jdvm_pkg::AXES; a++) begin
      vext[a] = AW'(smp[a]);
      if (vext[a] >= 0) begin
        mag[a]                   = vext[a] - dz_s;
        stage_d.lane[a].zero     = (vext[a] <= dz_s);
        stage_d.lane[a].neg      = 1'b0;
      end else begin
        mag[a]                   = -vext[a] - dz_s;
        stage_d.lane[a].zero     = (vext[a] >= -dz_s);
        stage_d.lane[a].neg      = 1'b1;
      end
      // quotient would reach 2^SAMPLE_BITS: clip without dividing
      stage_d.lane[a].sat = (den_s <= 0) || (mag[a] >= den2_s);
      stage_d.lane[a].rem = mag[a][jdvm_pkg::REM_W-1:0];
      stage_d.lane[a].quo = '0;
    end

    // Pedal mapping decisions
    xe      = AW'(smp[jdvm_pkg::AXIS_X]);
    ye      = AW'(smp[jdvm_pkg::AXIS_Y]);
    diff    = xe - ye;
    sum     = xe + ye;
    adiff   = unsigned'((diff < 0) ? -diff : diff);
    prod    = PW'(adiff) * PW'(jdvm_pkg::TOL_FACTOR);
    scale_w = PW'(1) << (jdvm_pkg::SAMPLE_BITS - 1);
    xpos    = (xe > 0);
    ypos    = (ye > 0);
    close   = xpos && ypos && (prod < scale_w);

    stage_d.side.pedal = cfg_i.pedal_mode;
    stage_d.side.xpos  = xpos;
    stage_d.side.ypos  = ypos;
    // both positive here, so the shift truncates toward zero
    stage_d.side.mean  = signed'(jdvm_pkg::SAMPLE_BITS'(sum >>> 1));
    if (close) begin
      stage_d.side.sel = jdvm_pkg::PED_MEAN;
    end else if ((xe > ye) && xpos) begin
      stage_d.side.sel = jdvm_pkg::PED_XSIDE;
    end else if ((ye > xe) && ypos) begin
      stage_d.side.sel = jdvm_pkg::PED_YSIDE;
    end else begin
      stage_d.side.sel = jdvm_pkg::PED_NONE;
    end

    // button priority, ignored in pedal mode
    if (cfg_i.pedal_mode) begin
      stage_d.side.action = jdvm_pkg::ACT_GOAL;
    end else if (in_i.btn_prepare) begin
      stage_d.side.action = jdvm_pkg::ACT_PREPARE;
    end else if (in_i.btn_start) begin
      stage_d.side.action = jdvm_pkg::ACT_START;
    end else if (in_i.btn_pause) begin
      stage_d.side.action = jdvm_pkg::ACT_PAUSE;
    end else if (in_i.btn_stop) begin
      stage_d.side.action = jdvm_pkg::ACT_STOP;
    end else if (in_i.btn_connect_goal && in_i.btn_connect_rpc) begin
      stage_d.side.action = jdvm_pkg::ACT_CONNECT_BOTH;
    end else if (cfg_i.connect_separately && in_i.btn_connect_goal) begin
      stage_d.side.action = jdvm_pkg::ACT_CONNECT_GOAL;
    end else if (cfg_i.connect_separately && in_i.btn_connect_rpc) begin
      stage_d.side.action = jdvm_pkg::ACT_CONNECT_RPC;
    end else if (in_i.btn_disconnect) begin
      stage_d.side.action = jdvm_pkg::ACT_DISCONNECT;
    end else begin
      stage_d.side.action = jdvm_pkg::ACT_GOAL;
    end
  end

  // Stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ===== rtl/jdvm_div_stage.sv =====
// One restoring-divider stage: a few quotient bits for each of the three axes.
module jdvm_div_stage #(
  parameter int NUM_STEPS = jdvm_pkg::STEPS_PER_STAGE
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  jdvm_pkg::stage_t           stage_i,
  input  logic [jdvm_pkg::DEN_W-1:0] den_i,
  output logic                       valid_o,
  output jdvm_pkg::stage_t           stage_o
);

  localparam int RW = jdvm_pkg::REM_W;
  localparam int SB = jdvm_pkg::SAMPLE_BITS;

  logic             valid_q;
  jdvm_pkg::stage_t stage_d, stage_q;
  logic [RW-1:0]    den_ext;
  logic             qbit;

  // Compare, subtract, shift: one quotient bit per step, MSB first
  always_comb begin
    den_ext = RW'(den_i);
    qbit    = 1'b0;
    stage_d = stage_i;
    for (int a = 0; a < jdvm_pkg::AXES; a++) begin
      for (int k = 0; k < NUM_STEPS; k++) begin
        qbit = (stage_d.lane[a].rem >= den_ext);
        if (qbit) begin
          stage_d.lane[a].rem = stage_d.lane[a].rem - den_ext;
        end
        stage_d.lane[a].rem = stage_d.lane[a].rem << 1;
        stage_d.lane[a].quo = {stage_d.lane[a].quo[SB-2:0], qbit};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ===== rtl/jdvm_back.sv =====
// Back stage: sign and saturation of each axis, mode mapping, result register.
module jdvm_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  jdvm_pkg::stage_t stage_i,
  output logic             valid_o,
  output jdvm_pkg::out_t   out_o
);

  localparam int SB = jdvm_pkg::SAMPLE_BITS;

  logic              valid_q;
  jdvm_pkg::out_t    out_d, out_q;
  logic [SB-1:0]     m   [jdvm_pkg::AXES];
  logic [SB-1:0]     mc  [jdvm_pkg::AXES];
  jdvm_pkg::sample_t dzp [jdvm_pkg::AXES];
  jdvm_pkg::sample_t dzn [jdvm_pkg::AXES];
  jdvm_pkg::sample_t lin, ang, lat;

  // Per axis: mapped value and its saturated negation
  always_comb begin
    for (int a = 0; a < jdvm_pkg::AXES; a++) begin
      if (stage_i.lane[a].sat || (stage_i.lane[a].quo > jdvm_pkg::SCALE_U)) begin
        m[a] = jdvm_pkg::SCALE_U;
      end else begin
        m[a] = stage_i.lane[a].quo;
      end
      mc[a] = (m[a] > jdvm_pkg::MAXPOS_U) ? jdvm_pkg::MAXPOS_U : m[a];
      if (stage_i.lane[a].zero) begin
        dzp[a] = '0;
        dzn[a] = '0;
      end else if (stage_i.lane[a].neg) begin
        dzp[a] = signed'(SB'(-m[a]));
        dzn[a] = signed'(mc[a]);
      end else begin
        dzp[a] = signed'(mc[a]);
        dzn[a] = signed'(SB'(-mc[a]));
      end
    end
  end

  // Mode mapping
  always_comb begin
    lin = '0;
    ang = '0;
    lat = '0;
    if (stage_i.side.pedal) begin
      ang = dzp[jdvm_pkg::AXIS_Z];
      case (stage_i.side.sel)
        jdvm_pkg::PED_MEAN: begin
          lin = stage_i.side.mean;
        end
        jdvm_pkg::PED_XSIDE: begin
          lat = dzp[jdvm_pkg::AXIS_X];
          lin = stage_i.side.ypos ? dzp[jdvm_pkg::AXIS_Y] : '0;
        end
        jdvm_pkg::PED_YSIDE: begin
          lat = dzn[jdvm_pkg::AXIS_Y];
          lin = stage_i.side.xpos ? dzp[jdvm_pkg::AXIS_X] : '0;
        end
        default: begin
          lin = '0;
        end
      endcase
    end else if (stage_i.side.action == jdvm_pkg::ACT_GOAL) begin
      lin = dzn[jdvm_pkg::AXIS_X];
      lat = dzn[jdvm_pkg::AXIS_Y];
      ang = dzn[jdvm_pkg::AXIS_Z];
    end
    out_d.linear_velocity  = lin;
    out_d.angular_velocity = ang;
    out_d.lateral_velocity = lat;
    out_d.action           = stage_i.side.action;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o = valid_q;
  assign out_o   = out_q;

endmodule

// ===== rtl/joystick_deadzone_velocity_mapper_core.sv =====
// Top level of the joystick deadzone velocity mapper pipeline.
//
// Usage:
//   Input: drive in_i and raise start; a beat is taken at each rising edge
//   where start is high and busy is low. busy is high only during reset and
//   in the first cycle after it, so one beat can enter every cycle.
//   Output: each beat yields one result, shown on out_o for exactly one
//   cycle with result_valid_o high. There is no backpressure: the receiver
//   must take every result when it appears.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (pedal mode, deadzone level, full scale, connect separately) at the
//   clock edge. Write only while no beat is in flight.
// Timing:
//   The pipeline has one front stage, one stage per four quotient bits of
//   the restoring divider and one back stage. Throughput is one beat per
//   cycle; the divider stages, each four compare-subtract steps deep on
//   three axes in parallel, set the clock.
// Reset:
//   rst_ni clears all valid bits and returns the registers to their reset
//   values; beats in flight are dropped.
module joystick_deadzone_velocity_mapper_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  jdvm_pkg::in_t              in_i,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [jdvm_pkg::CFG_W-1:0] cfg_wdata_i,
  output logic                       result_valid_o,
  output jdvm_pkg::out_t             out_o
);

  localparam int NSTG = jdvm_pkg::DIV_STAGES;

  jdvm_pkg::cfg_t             cfg_q;
  logic                       busy_q;
  logic [jdvm_pkg::DEN_W-1:0] den;
  logic                       vld_chain [NSTG+1];
  jdvm_pkg::stage_t           stg_chain [NSTG+1];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pedal_mode         <= 1'b0;
      cfg_q.deadzone_level     <= jdvm_pkg::DEADZONE_RST;
      cfg_q.full_scale         <= jdvm_pkg::FULL_SCALE_RST;
      cfg_q.connect_separately <= 1'b0;
    end else if (cfg_we_i) begin
      case (jdvm_pkg::cfg_idx_e'(cfg_idx_i))
        jdvm_pkg::CFG_PEDAL_MODE:  cfg_q.pedal_mode         <= cfg_wdata_i[0];
        jdvm_pkg::CFG_DEADZONE:    cfg_q.deadzone_level     <= cfg_wdata_i;
        jdvm_pkg::CFG_FULL_SCALE:  cfg_q.full_scale         <= cfg_wdata_i;
        jdvm_pkg::CFG_CONNECT_SEP: cfg_q.connect_separately <= cfg_wdata_i[0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Hold off beats for the cycle that follows reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy = busy_q;

  // Divisor; when not positive the front stage flags saturation instead
  assign den = jdvm_pkg::DEN_W'(cfg_q.full_scale) - jdvm_pkg::DEN_W'(cfg_q.deadzone_level);

  jdvm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy_q),
    .in_i    (in_i),
    .cfg_i   (cfg_q),
    .valid_o (vld_chain[0]),
    .stage_o (stg_chain[0])
  );

  // Divider stages, the last one takes the leftover bits
  for (genvar s = 0; s < NSTG; s++) begin : g_div
    localparam int LEFT  = jdvm_pkg::SAMPLE_BITS - s * jdvm_pkg::STEPS_PER_STAGE;
    localparam int STEPS = (LEFT < jdvm_pkg::STEPS_PER_STAGE) ? LEFT
                                                              : jdvm_pkg::STEPS_PER_STAGE;
    jdvm_div_stage #(
      .NUM_STEPS (STEPS)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_chain[s]),
      .stage_i (stg_chain[s]),
      .den_i   (den),
      .valid_o (vld_chain[s+1]),
      .stage_o (stg_chain[s+1])
    );
  end

  jdvm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_chain[NSTG]),
    .stage_i (stg_chain[NSTG]),
    .valid_o (result_valid_o),
    .out_o   (out_o)
  );

endmodule

// ===== rtl/jdvm_checker.sv =====
// Port-level checker for the mapper, bound to the top level.
`include "assert_macros.svh"

module jdvm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           result_valid_o,
  input jdvm_pkg::out_t out_o
);

  logic acc;

  assign acc = start && !busy;

  // every accepted beat gives a result after the fixed latency
  `JDVM_ASSERT_DLY(a_result_follows, clk_i, rst_ni, acc, jdvm_pkg::PIPE_LAT, result_valid_o)

  // no result without a beat accepted the same latency earlier
  `JDVM_ASSERT_DLY(a_no_spurious, clk_i, rst_ni, !acc, jdvm_pkg::PIPE_LAT, !result_valid_o)

  // button actions carry zero velocities
  `JDVM_ASSERT_IMP(a_action_zero_vel, clk_i, rst_ni, result_valid_o && (out_o.action != jdvm_pkg::ACT_GOAL), (out_o.linear_velocity == '0) && (out_o.angular_velocity == '0) && (out_o.lateral_velocity == '0))

endmodule

bind joystick_deadzone_velocity_mapper_core jdvm_checker u_jdvm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .out_o          (out_o)
);

// ===== bench/jdvm_velocity_checker.sv =====
// Checker for the mapper: tracks register writes, predicts each command and compares results.
module jdvm_velocity_checker
  import jdvm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  in_t              cmd_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             result_valid_i,
  input  out_t             result_i,
  output int               mismatches_o,
  output int               outstanding_o,
  output int               checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FULL_Q = longint'(1) <<< (SAMPLE_BITS - 1);
  localparam longint MAX_Q  = FULL_Q - 1;
  localparam int     PRED_DEPTH = 64;

  // Local copy of the register file
  logic             pedal_q;
  logic [CFG_W-1:0] deadzone_q;
  logic [CFG_W-1:0] full_scale_q;
  logic             separate_q;

  // Predicted velocity commands, a ring read oldest first
  out_t pred_fifo [PRED_DEPTH];
  int   wr_idx = 0;
  int   rd_idx = 0;

  int n_mismatch = 0;
  int n_pending  = 0;
  int n_checked  = 0;

  assign mismatches_o  = n_mismatch;
  assign outstanding_o = n_pending;
  assign checked_o     = n_checked;

  // Deadzone, rescale to full range, truncate and saturate
  function automatic longint dz_map(sample_t v);
    longint s, dz, den, mag, q;
    s   = longint'(v);
    dz  = longint'(deadzone_q);
    den = longint'(full_scale_q) - dz;
    if (s >= 0 && s <= dz) return 0;
    if (s < 0 && s >= -dz) return 0;
    mag = (s >= 0) ? s - dz : -(s + dz);
    q   = (den <= 0) ? FULL_Q : mag * FULL_Q / den;
    if (s >= 0) return (q > MAX_Q) ? MAX_Q : q;
    return (q > FULL_Q) ? -FULL_Q : -q;
  endfunction

  // Negation that clips the most negative value to full positive scale
  function automatic longint neg_sat(longint v);
    longint r;
    r = -v;
    return (r > MAX_Q) ? MAX_Q : r;
  endfunction

  // Velocity command for one sample set under the current registers
  function automatic out_t map_sample_set(in_t c);
    longint  x, y, lin, ang, lat, diff;
    action_e act;
    out_t    r;
    y    = longint'(c.axis_zero);
    x    = longint'(c.axis_one);
    lin  = 0;
    ang  = 0;
    lat  = 0;
    act  = ACT_GOAL;
    diff = (x > y) ? x - y : y - x;
    if (pedal_q) begin
      ang = dz_map(c.axis_two);
      if (x > 0 && y > 0 && diff * TOL_FACTOR < FULL_Q) begin
        lin = (x + y) / 2;
      end else if (x > y && x > 0) begin
        lat = dz_map(c.axis_one);
        if (y > 0) lin = dz_map(c.axis_zero);
      end else if (y > x && y > 0) begin
        lat = neg_sat(dz_map(c.axis_zero));
        if (x > 0) lin = dz_map(c.axis_one);
      end
    end else begin
      if (c.btn_prepare) act = ACT_PREPARE;
      else if (c.btn_start) act = ACT_START;
      else if (c.btn_pause) act = ACT_PAUSE;
      else if (c.btn_stop) act = ACT_STOP;
      else if (c.btn_connect_goal && c.btn_connect_rpc) act = ACT_CONNECT_BOTH;
      else if (separate_q && c.btn_connect_goal) act = ACT_CONNECT_GOAL;
      else if (separate_q && c.btn_connect_rpc) act = ACT_CONNECT_RPC;
      else if (c.btn_disconnect) act = ACT_DISCONNECT;
      // buttons take over; velocities only go out with a goal
      if (act == ACT_GOAL) begin
        lin = neg_sat(dz_map(c.axis_one));
        lat = neg_sat(dz_map(c.axis_zero));
        ang = neg_sat(dz_map(c.axis_two));
      end
    end
    r.linear_velocity  = sample_t'(lin);
    r.angular_velocity = sample_t'(ang);
    r.lateral_velocity = sample_t'(lat);
    r.action           = act;
    return r;
  endfunction

  task automatic note_mismatch(string field, longint want, longint got);
    n_mismatch++;
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
  endtask

  // Predict on each accepted beat, compare each result, follow register writes
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      pedal_q      <= 1'b0;
      deadzone_q   <= DEADZONE_RST;
      full_scale_q <= FULL_SCALE_RST;
      separate_q   <= 1'b0;
      wr_idx        = 0;
      rd_idx        = 0;
      n_pending     = 0;
    end else begin
      if (start_i && !busy_i) begin
        pred_fifo[wr_idx] = map_sample_set(cmd_i);
        wr_idx            = (wr_idx + 1) % PRED_DEPTH;
        n_pending++;
      end
      if (result_valid_i) begin
        if (n_pending == 0) begin
          n_mismatch++;
          $display("%0t: unexpected result: expected none, got %h", $time, result_i);
        end else begin
          want   = pred_fifo[rd_idx];
          rd_idx = (rd_idx + 1) % PRED_DEPTH;
          n_pending--;
          n_checked++;
          if (result_i.linear_velocity !== want.linear_velocity)
            note_mismatch("linear_velocity", want.linear_velocity, result_i.linear_velocity);
          if (result_i.angular_velocity !== want.angular_velocity)
            note_mismatch("angular_velocity", want.angular_velocity,
                          result_i.angular_velocity);
          if (result_i.lateral_velocity !== want.lateral_velocity)
            note_mismatch("lateral_velocity", want.lateral_velocity,
                          result_i.lateral_velocity);
          if (result_i.action !== want.action)
            note_mismatch("action", want.action, result_i.action);
        end
      end
      // writes land after this edge's prediction
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PEDAL_MODE:  pedal_q      <= cfg_wdata_i[0];
          CFG_DEADZONE:    deadzone_q   <= cfg_wdata_i;
          CFG_FULL_SCALE:  full_scale_q <= cfg_wdata_i;
          CFG_CONNECT_SEP: separate_q   <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== bench/tb_joystick_deadzone_velocity_mapper_core.sv =====
// Testbench top for the mapper: clock, reset, register settings, beat stimulus and verdict.
module tb_joystick_deadzone_velocity_mapper_core;
  import jdvm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES      = 10;
  localparam int PHASE_BEATS = 40;
  localparam int DRAIN_LIMIT = 1000;

  // Button masks, prepare down to disconnect
  localparam logic [6:0] BTN_NONE       = 7'b0000000;
  localparam logic [6:0] BTN_PREPARE    = 7'b1000000;
  localparam logic [6:0] BTN_START      = 7'b0100000;
  localparam logic [6:0] BTN_PAUSE      = 7'b0010000;
  localparam logic [6:0] BTN_STOP       = 7'b0001000;
  localparam logic [6:0] BTN_GOAL       = 7'b0000100;
  localparam logic [6:0] BTN_RPC        = 7'b0000010;
  localparam logic [6:0] BTN_DISCONNECT = 7'b0000001;
  localparam logic [6:0] BTN_ALL        = 7'b1111111;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  in_t              in_i;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             result_valid_o;
  out_t             out_o;

  int mismatches, outstanding, checked;

  // Settings as last written, used to aim the stimulus
  logic             tb_pedal = 1'b0;
  logic [CFG_W-1:0] tb_dz    = DEADZONE_RST;
  logic [CFG_W-1:0] tb_fs    = FULL_SCALE_RST;

  int n_sent     = 0;
  int n_settings = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  joystick_deadzone_velocity_mapper_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .out_o          (out_o)
  );

  jdvm_velocity_checker u_cmd_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .cmd_i          (in_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_i (result_valid_o),
    .result_i       (out_o),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .checked_o      (checked)
  );

  function automatic in_t beat_of(int y, int x, int z, logic [6:0] btns);
    in_t b;
    b.axis_zero = sample_t'(y);
    b.axis_one  = sample_t'(x);
    b.axis_two  = sample_t'(z);
    {b.btn_prepare, b.btn_start, b.btn_pause, b.btn_stop,
     b.btn_connect_goal, b.btn_connect_rpc, b.btn_disconnect} = btns;
    return b;
  endfunction

  // Axis sample biased toward the deadzone and full-scale edges
  function automatic sample_t pick_axis();
    int dzv, fsv;
    dzv = int'(tb_dz);
    fsv = int'(tb_fs);
    case ($urandom_range(0, 13))
      0:       return sample_t'(-32768);
      1:       return sample_t'(32767);
      2:       return sample_t'(0);
      3:       return sample_t'(dzv);
      4:       return sample_t'(-dzv);
      5:       return sample_t'(dzv + 1);
      6:       return sample_t'(-dzv - 1);
      7:       return sample_t'(fsv);
      8:       return sample_t'(-fsv);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic in_t make_item();
    in_t        b;
    int         base, pair;
    logic [6:0] btns;
    btns = BTN_NONE;
    b    = beat_of(pick_axis(), pick_axis(), pick_axis(), BTN_NONE);
    // pedals pressed together and close: the mean path
    if (tb_pedal && $urandom_range(0, 2) == 0) begin
      base = int'($urandom_range(1, 32767));
      pair = base + int'($urandom_range(0, 660)) - 330;
      if (pair < 1) pair = 1;
      if (pair > 32767) pair = 32767;
      b.axis_zero = sample_t'(base);
      b.axis_one  = sample_t'(pair);
    end
    if (tb_pedal) begin
      btns = 7'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0, 1:    btns = BTN_NONE;
        2:       btns = BTN_DISCONNECT << $urandom_range(0, 6);
        default: btns = 7'($urandom);
      endcase
    end
    {b.btn_prepare, b.btn_start, b.btn_pause, b.btn_stop,
     b.btn_connect_goal, b.btn_connect_rpc, b.btn_disconnect} = btns;
    return b;
  endfunction

  // Hold the beat until a rising edge takes it; busy is stable from the falling edge
  task automatic send_beat(in_t b);
    logic took;
    start <= 1'b1;
    in_i  <= b;
    do begin
      @(negedge clk_i);
      took = !busy;
      @(posedge clk_i);
    end while (!took);
    n_sent++;
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    in_i  <= make_item();
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stop sending, let every expected result come back, then wait for the pipeline to run empty
  task automatic quiesce();
    int waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(negedge clk_i);
      waited++;
    end while (outstanding != 0 && waited < DRAIN_LIMIT);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  // Write all four registers on consecutive edges
  task automatic set_config(logic pedal, int dz, int fs, logic sep);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_PEDAL_MODE;
    cfg_wdata_i <= CFG_W'(pedal);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_DEADZONE;
    cfg_wdata_i <= CFG_W'(dz);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_FULL_SCALE;
    cfg_wdata_i <= CFG_W'(fs);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_CONNECT_SEP;
    cfg_wdata_i <= CFG_W'(sep);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tb_pedal    = pedal;
    tb_dz       = CFG_W'(dz);
    tb_fs       = CFG_W'(fs);
    n_settings++;
  endtask

  initial begin
    #200000;
    $display("joystick_deadzone_velocity_mapper_core verification failed");
    $finish;
  end

  initial begin
    int remaining, burst, dz, fs;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    in_i        <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_PEDAL_MODE;
    cfg_wdata_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, joystick mapping: axis extremes, deadzone edges, button priority
    send_beat(beat_of(0, 0, 0, BTN_NONE));
    send_beat(beat_of(32767, 32767, 32767, BTN_NONE));
    send_beat(beat_of(-32768, -32768, -32768, BTN_NONE));
    send_beat(beat_of(3277, -3277, 3278, BTN_NONE));
    send_beat(beat_of(-3278, 100, 20000, BTN_NONE));
    send_beat(beat_of(9000, -9000, 500, BTN_PREPARE));
    send_beat(beat_of(9000, -9000, 500, BTN_START | BTN_PAUSE));
    send_beat(beat_of(9000, -9000, 500, BTN_PAUSE | BTN_STOP));
    send_beat(beat_of(9000, -9000, 500, BTN_STOP | BTN_GOAL));
    send_beat(beat_of(9000, -9000, 500, BTN_GOAL | BTN_RPC | BTN_DISCONNECT));
    send_beat(beat_of(9000, -9000, 500, BTN_GOAL));
    send_beat(beat_of(9000, -9000, 500, BTN_RPC | BTN_DISCONNECT));
    send_beat(beat_of(9000, -9000, 500, BTN_ALL));
    quiesce();

    // Single connect buttons honored
    set_config(1'b0, 3277, 32767, 1'b1);
    send_beat(beat_of(1, 2, 3, BTN_GOAL | BTN_DISCONNECT));
    send_beat(beat_of(1, 2, 3, BTN_RPC | BTN_DISCONNECT));
    quiesce();

    // Pedal mapping: mean at the tolerance edge, each side, negatives, ignored buttons
    set_config(1'b1, 3277, 32767, 1'b0);
    send_beat(beat_of(20000, 20100, 5000, BTN_NONE));
    send_beat(beat_of(20000, 20327, 0, BTN_NONE));
    send_beat(beat_of(20000, 20328, 0, BTN_NONE));
    send_beat(beat_of(10000, 5000, -5000, BTN_PREPARE));
    send_beat(beat_of(10000, -5000, 0, BTN_NONE));
    send_beat(beat_of(-100, -200, 0, BTN_NONE));
    send_beat(beat_of(-32768, 32767, -32768, BTN_ALL));
    send_beat(beat_of(32767, 32767, 32767, BTN_NONE));
    quiesce();

    // Random beats in bursts across a spread of settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(1'b0, 0, 32767, 1'b1);
        1: set_config(1'b1, 0, 32767, 1'b0);
        2: set_config(1'b0, 32766, 32767, 1'b0);
        3: set_config(1'b1, 20000, 10000, 1'b1);   // full scale below deadzone
        4: set_config(1'b0, 0, 1, 1'b1);
        5: set_config(1'b1, 3277, 32767, 1'b0);
        default: begin
          dz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32766) : $urandom_range(0, 8000);
          fs = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32767)
                                           : $urandom_range(dz + 1, 32767);
          set_config(1'($urandom), dz, fs, 1'($urandom));
        end
      endcase
      remaining = PHASE_BEATS;
      while (remaining > 0) begin
        burst = $urandom_range(1, 24);
        while (burst > 0 && remaining > 0) begin
          send_beat(make_item());
          burst--;
          remaining--;
        end
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
      end
      quiesce();
    end

    $display("Run covered %0d beats under %0d register settings: joystick and pedal mapping,",
             n_sent, n_settings);
    $display("button priority and deadzone/full-scale extremes; %0d results compared.", checked);
    if (outstanding != 0)
      $display("%0t: %0d expected results never arrived", $time, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("joystick_deadzone_velocity_mapper_core verification clean");
    end else begin
      $display("joystick_deadzone_velocity_mapper_core verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/jdvm_pkg.sv
rtl/jdvm_front.sv
rtl/jdvm_div_stage.sv
rtl/jdvm_back.sv
rtl/joystick_deadzone_velocity_mapper_core.sv
rtl/jdvm_checker.sv
bench/jdvm_velocity_checker.sv
bench/tb_joystick_deadzone_velocity_mapper_core.sv
